// ----- src/julia_escape_time_iterator_core_assert.svh -----
// Assertion macros for the Julia escape-time iterator core.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef JULIA_ESCAPE_TIME_ITERATOR_CORE_ASSERT_SVH
`define JULIA_ESCAPE_TIME_ITERATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define JET_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("julia core assertion failed");
// Next-cycle implication
`define JET_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("julia core assertion failed");
`else
`define JET_ASSERT_IMP(lbl, ante, cons)
`define JET_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- src/jet_pkg.sv -----
// Shared types, constants and helpers for the Julia escape-time iterator.
// No dependencies.
package jet_pkg;

  // Fixed port widths
  localparam int PIX_W     = 12;
  localparam int CNT_OUT_W = 16;
  localparam int REG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MAX_IT_W  = 16;

  // Fraction bits of the register and start-point format (Q4.28)
  localparam int IN_FRAC   = 28;

  // Multiplier slice width and start-point queue depth
  localparam int MUL_CHUNK = 32;
  localparam int Q_DEPTH   = 2;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_C_REAL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C_IMAG      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd6;

  localparam logic [MAX_IT_W-1:0] MAX_ITER_RESET = 16'd256;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } jet_q_stat_t;

  // Back end status
  typedef struct packed {
    logic busy;
    logic result_pending;
  } jet_back_stat_t;

  // Q.28 value (within +-8) to a format with frac fraction bits; floor when narrowing
  function automatic logic signed [63:0] q28_to_int(input logic signed [32:0] v,
                                                    input int frac);
    logic signed [63:0] w;
    w = 64'(v);
    if (frac >= IN_FRAC) begin
      return w <<< (frac - IN_FRAC);
    end else begin
      return w >>> (IN_FRAC - frac);
    end
  endfunction

endpackage

// ----- src/jet_if.sv -----
// Handshake channel interfaces for the Julia escape-time iterator.
// Depends on jet_pkg.
interface jet_in_if import jet_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_column;
  logic [PIX_W-1:0] pixel_row;

  modport source (output valid, output pixel_column, output pixel_row, input ready);
  modport sink   (input valid, input pixel_column, input pixel_row, output ready);
endinterface

interface jet_out_if import jet_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CNT_OUT_W-1:0] iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink   (input valid, input iteration_count, output ready);
endinterface

interface jet_cfg_if import jet_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/julia_escape_time_iterator_core.sv -----
// Top level of the Julia escape-time iterator: register file, front end,
// start-point queue and back end. Depends on jet_pkg, jet_if, jet_front,
// jet_queue, jet_back and julia_escape_time_iterator_core_assert.svh.
//
// Each pixel transaction (column, row) gives one result transaction holding
// the escape count of z0 = origin + index*step under z = z*z + c, capped at
// max_iterations. The front end takes a pixel every cycle while the two-entry
// start-point queue has room; the back end works on one point at a time.
// One shared 32x32 multiplier in the back end sets the rate: each product
// is built from K*K slice products with K = ceil((COORD_FRAC_BITS+4)/32),
// and an iteration runs three products: the squares of both parts of z,
// then the cross term. When the point escapes, the final escape test costs
// only the two squares. Registers must be written only while the block is
// idle; the block itself does not enforce this. The write port is always
// ready.
`include "julia_escape_time_iterator_core_assert.svh"

module julia_escape_time_iterator_core import jet_pkg::*; #(
  parameter int COORD_FRAC_BITS  = 28,
  parameter int PIXEL_INDEX_BITS = 12,
  parameter int COUNT_BITS       = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  jet_in_if.sink    in_pix,
  jet_out_if.source out_res,
  jet_cfg_if.sink   cfg_wr
);

  localparam int ZW = COORD_FRAC_BITS + 5;
  localparam int CW = (COUNT_BITS < CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;

  logic signed [REG_W-1:0] c_real_r, c_imag_r;
  logic signed [REG_W-1:0] origin_real_r, origin_imag_r;
  logic signed [REG_W-1:0] step_real_r, step_imag_r;
  logic [MAX_IT_W-1:0]     max_iter_r;

  logic                    q_push, q_pop;
  logic [2*ZW-1:0]         q_wdata, q_rdata;
  jet_q_stat_t             q_stat;
  jet_back_stat_t          back_stat;

  // Register file writes; unknown indexes are dropped
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_real_r      <= '0;
      c_imag_r      <= '0;
      origin_real_r <= '0;
      origin_imag_r <= '0;
      step_real_r   <= '0;
      step_imag_r   <= '0;
      max_iter_r    <= MAX_ITER_RESET;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_C_REAL:      c_real_r      <= cfg_wr.data;
        REG_C_IMAG:      c_imag_r      <= cfg_wr.data;
        REG_ORIGIN_REAL: origin_real_r <= cfg_wr.data;
        REG_ORIGIN_IMAG: origin_imag_r <= cfg_wr.data;
        REG_STEP_REAL:   step_real_r   <= cfg_wr.data;
        REG_STEP_IMAG:   step_imag_r   <= cfg_wr.data;
        REG_MAX_ITER:    max_iter_r    <= cfg_wr.data[MAX_IT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  jet_front #(
    .COORD_FRAC_BITS  (COORD_FRAC_BITS),
    .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pix      (in_pix),
    .origin_real (origin_real_r),
    .origin_imag (origin_imag_r),
    .step_real   (step_real_r),
    .step_imag   (step_imag_r),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  jet_queue #(
    .W     (2 * ZW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  jet_back #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .c_real         (c_real_r),
    .c_imag         (c_imag_r),
    .max_iterations (max_iter_r),
    .q_stat         (q_stat),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_res        (out_res),
    .stat           (back_stat)
  );

  // Checks
  `JET_ASSERT_IMP(a_push_has_room, q_push, !q_stat.full)
  `JET_ASSERT_NXT(a_pop_starts_work, q_pop, back_stat.busy)
  `JET_ASSERT_IMP(a_busy_from_queue, $rose(back_stat.busy), $past(!q_stat.empty))
  `JET_ASSERT_IMP(a_count_capped, out_res.valid, out_res.iteration_count <= CNT_OUT_W'(max_iter_r[CW-1:0]))

endmodule

// ----- src/jet_front.sv -----
// Front end: takes pixel transactions, forms the start point z0 = origin + index*step
// and pushes it into the start-point queue. Depends on jet_pkg and jet_if.
module jet_front import jet_pkg::*; #(
  parameter int COORD_FRAC_BITS  = 28,
  parameter int PIXEL_INDEX_BITS = 12,
  localparam int ZW = COORD_FRAC_BITS + 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  jet_in_if.sink                   in_pix,
  input  logic signed [REG_W-1:0]  origin_real,
  input  logic signed [REG_W-1:0]  origin_imag,
  input  logic signed [REG_W-1:0]  step_real,
  input  logic signed [REG_W-1:0]  step_imag,
  input  jet_q_stat_t              q_stat,
  output logic                     q_push,
  output logic [2*ZW-1:0]          q_wdata
);

  localparam int IW   = (PIXEL_INDEX_BITS < PIX_W) ? PIXEL_INDEX_BITS : PIX_W;
  localparam int PRW  = REG_W + IW + 1;
  localparam int SUMW = PRW + 1;
  localparam logic signed [SUMW-1:0] LIM_S = SUMW'(1) << (IN_FRAC + 3);
  localparam logic signed [SUMW-1:0] NLIM_S = -LIM_S;

  logic                   s1_valid_r, s1_valid_nxt;
  logic signed [PRW-1:0]  prod_re_r, prod_im_r;
  logic [IW-1:0]          col_idx, row_idx;
  logic                   in_take;
  logic signed [SUMW-1:0] sum_re, sum_im;
  logic signed [32:0]     st_re, st_im;
  logic signed [63:0]     zr0_w, zi0_w;

  // Saturate to [-8, +8] in Q.28
  function automatic logic signed [32:0] clamp8(input logic signed [SUMW-1:0] v);
    logic signed [32:0] r;
    if (v > LIM_S) begin
      r = LIM_S[32:0];
    end else if (v < NLIM_S) begin
      r = NLIM_S[32:0];
    end else begin
      r = v[32:0];
    end
    return r;
  endfunction

  // Stage 1: index times step
  assign col_idx      = in_pix.pixel_column[IW-1:0];
  assign row_idx      = in_pix.pixel_row[IW-1:0];
  assign q_push       = s1_valid_r && !q_stat.full;
  assign in_pix.ready = !s1_valid_r || !q_stat.full;
  assign in_take      = in_pix.valid && in_pix.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      prod_re_r <= step_real * $signed({1'b0, col_idx});
      prod_im_r <= step_imag * $signed({1'b0, row_idx});
    end
  end

  // Stage 2: add origin, saturate, convert to iteration format
  assign sum_re  = SUMW'(origin_real) + SUMW'(prod_re_r);
  assign sum_im  = SUMW'(origin_imag) + SUMW'(prod_im_r);
  assign st_re   = clamp8(sum_re);
  assign st_im   = clamp8(sum_im);
  assign zr0_w   = q28_to_int(st_re, COORD_FRAC_BITS);
  assign zi0_w   = q28_to_int(st_im, COORD_FRAC_BITS);
  assign q_wdata = {zr0_w[ZW-1:0], zi0_w[ZW-1:0]};

endmodule

// ----- src/jet_queue.sv -----
// Small FIFO of start points between the front and back ends.
// Depends on jet_pkg.
module jet_queue import jet_pkg::*; #(
  parameter int W     = 66,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output jet_q_stat_t  stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == (AW+1)'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Pointers wrap at DEPTH
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ----- src/jet_mul.sv -----
// Shared magnitude multiplier: (a*b) >> FRAC from 32x32 partial products,
// one per cycle, accumulated in a register. Depends on jet_pkg.
module jet_mul import jet_pkg::*; #(
  parameter int FRAC = 28,
  localparam int MW = FRAC + 4,
  localparam int SW = FRAC + 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [MW-1:0] a,
  input  logic [MW-1:0] b,
  output logic          done,
  output logic [SW-1:0] res
);

  localparam int NC   = (MW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int PADW = NC * MUL_CHUNK;
  localparam int ACCW = 2 * PADW;
  localparam int NCW  = (NC > 1) ? $clog2(NC) : 1;
  localparam logic [NCW-1:0] LAST_IDX = NCW'(NC - 1);

  logic [PADW-1:0]        a_r, b_r;
  logic [NCW-1:0]         i_r, j_r;
  logic                   issuing_r, ppv_r, done_r, pplast_r;
  logic [2*MUL_CHUNK-1:0] pp_r;
  logic [NCW:0]           pos_r;
  logic [ACCW-1:0]        acc_r;
  logic [MUL_CHUNK-1:0]   a_chunk, b_chunk;
  logic                   last_pp;

  assign a_chunk = a_r[i_r*MUL_CHUNK +: MUL_CHUNK];
  assign b_chunk = b_r[j_r*MUL_CHUNK +: MUL_CHUNK];
  assign last_pp = (i_r == LAST_IDX) && (j_r == LAST_IDX);
  assign done    = done_r;
  assign res     = acc_r[FRAC +: SW];

  // Sequencing over slice pairs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r <= 1'b0;
      ppv_r     <= 1'b0;
      done_r    <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
    end else begin
      ppv_r  <= issuing_r;
      done_r <= ppv_r && pplast_r;
      if (start) begin
        issuing_r <= 1'b1;
        i_r       <= '0;
        j_r       <= '0;
      end else if (issuing_r) begin
        if (last_pp) begin
          issuing_r <= 1'b0;
        end else if (j_r == LAST_IDX) begin
          j_r <= '0;
          i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
    end
  end

  // Partial product, then shifted accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= PADW'(a);
      b_r   <= PADW'(b);
      acc_r <= '0;
    end else if (ppv_r) begin
      acc_r <= acc_r + (ACCW'(pp_r) << (pos_r * MUL_CHUNK));
    end
    if (issuing_r) begin
      pp_r     <= a_chunk * b_chunk;
      pos_r    <= {1'b0, i_r} + {1'b0, j_r};
      pplast_r <= last_pp;
    end
  end

endmodule

// ----- src/jet_back.sv -----
// Back end: iterates z = z*z + c on one start point at a time with the shared
// multiplier and holds the escape count in the output register.
// Depends on jet_pkg, jet_if and jet_mul.
module jet_back import jet_pkg::*; #(
  parameter int COORD_FRAC_BITS = 28,
  parameter int COUNT_BITS      = 16,
  localparam int ZW = COORD_FRAC_BITS + 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [REG_W-1:0] c_real,
  input  logic signed [REG_W-1:0] c_imag,
  input  logic [MAX_IT_W-1:0]     max_iterations,
  input  jet_q_stat_t             q_stat,
  input  logic [2*ZW-1:0]         q_rdata,
  output logic                    q_pop,
  jet_out_if.source               out_res,
  output jet_back_stat_t          stat
);

  localparam int F  = COORD_FRAC_BITS;
  localparam int MW = F + 4;
  localparam int SW = F + 7;
  localparam int EW = F + 10;
  localparam int CW = (COUNT_BITS < CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
  localparam logic [SW:0] FOUR = (SW+1)'(4) << F;
  localparam logic signed [EW-1:0] LIM_E  = EW'(8) << F;
  localparam logic signed [EW-1:0] NLIM_E = -LIM_E;

  // Sequencer states
  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_LOOP = 3'd1;
  localparam logic [2:0] B_WR2  = 3'd2;
  localparam logic [2:0] B_WI2  = 3'd3;
  localparam logic [2:0] B_TEST = 3'd4;
  localparam logic [2:0] B_WP   = 3'd5;
  localparam logic [2:0] B_DONE = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic signed [ZW-1:0]   zr_r, zr_nxt, zi_r, zi_nxt;
  logic [CW-1:0]          n_r, n_nxt;
  logic [SW-1:0]          r2_r, r2_nxt, i2_r, i2_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CNT_OUT_W-1:0]   out_count_r, out_count_nxt;
  logic [CW-1:0]          limit;
  logic signed [63:0]     cr_w, ci_w;
  logic signed [EW-1:0]   cr_e, ci_e;
  logic [MW-1:0]          zr_mag, zi_mag;
  logic                   mul_start, mul_done;
  logic [MW-1:0]          mul_a, mul_b;
  logic [SW-1:0]          mul_res;
  logic                   escaped;
  logic signed [EW-1:0]   p_ext, prod_s, r2_e, i2_e, re_e, im_e;

  function automatic logic signed [ZW-1:0] clamp8(input logic signed [EW-1:0] v);
    logic signed [ZW-1:0] r;
    if (v > LIM_E) begin
      r = LIM_E[ZW-1:0];
    end else if (v < NLIM_E) begin
      r = NLIM_E[ZW-1:0];
    end else begin
      r = v[ZW-1:0];
    end
    return r;
  endfunction

  // Constant c in iteration format, sign carried into the wide format
  assign cr_w  = q28_to_int(33'(c_real), F);
  assign ci_w  = q28_to_int(33'(c_imag), F);
  assign cr_e  = EW'($signed(cr_w[ZW-1:0]));
  assign ci_e  = EW'($signed(ci_w[ZW-1:0]));
  assign limit = max_iterations[CW-1:0];

  // Magnitudes of z
  assign zr_mag = zr_r[ZW-1] ? MW'(-zr_r) : MW'(zr_r);
  assign zi_mag = zi_r[ZW-1] ? MW'(-zi_r) : MW'(zi_r);

  jet_mul #(
    .FRAC (F)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  // Escape test and next z
  assign escaped = ({1'b0, r2_r} + {1'b0, i2_r}) >= FOUR;
  assign p_ext   = $signed({3'b000, mul_res});
  assign prod_s  = (zr_r[ZW-1] ^ zi_r[ZW-1]) ? -p_ext : p_ext;
  assign r2_e    = $signed({3'b000, r2_r});
  assign i2_e    = $signed({3'b000, i2_r});
  assign re_e    = r2_e - i2_e + cr_e;
  assign im_e    = (prod_s <<< 1) + ci_e;

  // Iteration sequencer
  always_comb begin
    state_nxt     = state_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    n_nxt         = n_r;
    r2_nxt        = r2_r;
    i2_nxt        = i2_r;
    mul_start     = 1'b0;
    mul_a         = zr_mag;
    mul_b         = zr_mag;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          zr_nxt    = q_rdata[2*ZW-1:ZW];
          zi_nxt    = q_rdata[ZW-1:0];
          n_nxt     = '0;
          state_nxt = B_LOOP;
        end
      end
      B_LOOP: begin
        if (n_r >= limit) begin
          state_nxt = B_DONE;
        end else begin
          mul_start = 1'b1;
          state_nxt = B_WR2;
        end
      end
      B_WR2: begin
        mul_a = zi_mag;
        mul_b = zi_mag;
        if (mul_done) begin
          r2_nxt    = mul_res;
          mul_start = 1'b1;
          state_nxt = B_WI2;
        end
      end
      B_WI2: begin
        if (mul_done) begin
          i2_nxt    = mul_res;
          state_nxt = B_TEST;
        end
      end
      B_TEST: begin
        mul_b = zi_mag;
        if (escaped) begin
          state_nxt = B_DONE;
        end else begin
          mul_start = 1'b1;
          state_nxt = B_WP;
        end
      end
      B_WP: begin
        if (mul_done) begin
          zr_nxt    = clamp8(re_e);
          zi_nxt    = clamp8(im_e);
          n_nxt     = n_r + 1'b1;
          state_nxt = B_LOOP;
        end
      end
      B_DONE: begin
        // Output register frees up when the pending transaction is taken
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = CNT_OUT_W'(n_r);
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    n_r         <= n_nxt;
    r2_r        <= r2_nxt;
    i2_r        <= i2_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.iteration_count = out_count_r;
  assign stat.busy               = (state_r != B_IDLE);
  assign stat.result_pending     = out_valid_r;

endmodule

// ----- dv/jet_count_checker.sv -----
`timescale 1ns / 1ps
// Checker for the Julia escape-time iterator core: tracks register writes,
// predicts the escape count of every pixel transaction and compares results in
// order. Depends on jet_pkg and the channel interfaces in jet_if.
module jet_count_checker import jet_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  jet_in_if    in_mon,
  jet_out_if   out_mon,
  jet_cfg_if   cfg_mon,
  output int   mismatches,
  output int   outstanding,
  output int   checked,
  output int   capped,
  output int   instant
);

  // Internal fraction bits equal the register format at the default build
  localparam int                FRAC       = 28;
  localparam longint            SAT        = longint'(8) <<< FRAC;
  localparam longint unsigned   ESCAPE_R2  = 64'd4 << FRAC;
  localparam int                REPORT_MAX = 50;

  typedef struct packed {
    logic [PIX_W-1:0]     col;
    logic [PIX_W-1:0]     row;
    logic [CNT_OUT_W-1:0] count;
  } pixel_count_t;

  // Register shadow
  logic signed [REG_W-1:0] c_re, c_im, org_re, org_im, stp_re, stp_im;
  logic [MAX_IT_W-1:0]     iter_cap;

  pixel_count_t counts_due[$];

  task automatic report_mismatch(string what);
    // keep the log readable when everything goes wrong
    if (mismatches < REPORT_MAX) $display("%0t ns  mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic longint saturate(longint v);
    if (v > SAT) return SAT;
    if (v < -SAT) return -SAT;
    return v;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Magnitudes never exceed 2^31, so the full product fits in 64 bits
  function automatic longint unsigned frac_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> FRAC;
  endfunction

  function automatic longint start_point(logic signed [REG_W-1:0] base,
                                         logic signed [REG_W-1:0] inc,
                                         logic [PIX_W-1:0] idx);
    return saturate(longint'(base) + longint'(inc) * longint'(idx));
  endfunction

  // Escape count of one pixel under the current register settings
  function automatic logic [CNT_OUT_W-1:0] escape_count(logic [PIX_W-1:0] col,
                                                        logic [PIX_W-1:0] row);
    longint          zr, zi, prod;
    longint unsigned r2, i2, p;
    int              n;
    bit              escaped;
    zr = start_point(org_re, stp_re, col);
    zi = start_point(org_im, stp_im, row);
    n = 0;
    escaped = 1'b0;
    while (!escaped && n < iter_cap) begin
      r2 = frac_mul(magnitude(zr), magnitude(zr));
      i2 = frac_mul(magnitude(zi), magnitude(zi));
      if (r2 + i2 >= ESCAPE_R2) begin
        escaped = 1'b1;
      end else begin
        // cross term: magnitude product truncated, then signed
        p = frac_mul(magnitude(zr), magnitude(zi));
        prod = ((zr < 0) != (zi < 0)) ? -longint'(p) : longint'(p);
        zr = saturate(longint'(r2) - longint'(i2) + longint'(c_re));
        zi = saturate(2 * prod + longint'(c_im));
        n++;
      end
    end
    return CNT_OUT_W'(n);
  endfunction

  always @(posedge clk) begin : track
    pixel_count_t due;
    if (!rst_n) begin
      c_re     = '0;
      c_im     = '0;
      org_re   = '0;
      org_im   = '0;
      stp_re   = '0;
      stp_im   = '0;
      iter_cap = MAX_ITER_RESET;
      counts_due.delete();
    end else begin
      // result side first: a result never leaves in the cycle its pixel enters
      if (out_mon.valid && out_mon.ready) begin
        if (counts_due.size() == 0) begin
          report_mismatch($sformatf("result count=%0d with no pixel pending",
                                    out_mon.iteration_count));
        end else begin
          due = counts_due.pop_front();
          checked++;
          if (out_mon.iteration_count !== due.count)
            report_mismatch($sformatf("pixel (%0d,%0d) count=%0d, predicted %0d",
                                      due.col, due.row, out_mon.iteration_count,
                                      due.count));
        end
      end

      // register writes; unmapped indexes are ignored
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_C_REAL:      c_re     = cfg_mon.data;
          REG_C_IMAG:      c_im     = cfg_mon.data;
          REG_ORIGIN_REAL: org_re   = cfg_mon.data;
          REG_ORIGIN_IMAG: org_im   = cfg_mon.data;
          REG_STEP_REAL:   stp_re   = cfg_mon.data;
          REG_STEP_IMAG:   stp_im   = cfg_mon.data;
          REG_MAX_ITER:    iter_cap = cfg_mon.data[MAX_IT_W-1:0];
          default: ;
        endcase
      end

      // pixel side: predict and queue
      if (in_mon.valid && in_mon.ready) begin
        due.col   = in_mon.pixel_column;
        due.row   = in_mon.pixel_row;
        due.count = escape_count(in_mon.pixel_column, in_mon.pixel_row);
        counts_due.push_back(due);
        if (due.count == iter_cap) capped++;
        else if (due.count == 0) instant++;
      end
    end
    outstanding = counts_due.size();
  end

endmodule

// ----- dv/tb_julia_escape_time_iterator_core.sv -----
`timescale 1ns / 1ps
// Testbench top for the Julia escape-time iterator core: clock, reset, pixel
// and register stimulus, result back-pressure, watchdog and verdict.
// Depends on jet_pkg, jet_if, the core and jet_count_checker.
module tb_julia_escape_time_iterator_core;
  import jet_pkg::*;

  localparam int                   CLK_HALF    = 6;
  localparam int                   STALL_LIMIT = 20000;
  localparam int                   RAND_PHASES = 8;
  localparam int                   PHASE_ITEMS = 110;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 3'd7;  // not mapped
  localparam logic [REG_W-1:0]     ONE         = 32'h1000_0000;  // 1.0 in Q4.28

  logic clk;
  logic rst_n;
  bit   calm;
  int   mismatches, outstanding, checked, capped, instant;
  int   settings;
  int   stall_cycles;

  jet_in_if  in_ch ();
  jet_out_if out_ch ();
  jet_cfg_if cfg_ch ();

  julia_escape_time_iterator_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_ch),
    .out_res (out_ch),
    .cfg_wr  (cfg_ch)
  );

  jet_count_checker count_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked),
    .capped      (capped),
    .instant     (instant)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [REG_W-1:0] q428(real x);
    return REG_W'(longint'(x * 268435456.0));
  endfunction

  // Uniform offset in [-span, +span], two's complement
  function automatic logic [REG_W-1:0] jitter(int unsigned span);
    return REG_W'($urandom_range(0, 2 * span)) - REG_W'(span);
  endfunction

  // One register write; the last of a group drops valid afterwards
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data, bit last);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (last) begin
      @(negedge clk);
      cfg_ch.valid <= 1'b0;
    end
  endtask

  task automatic load_view(logic [REG_W-1:0] cr, logic [REG_W-1:0] ci,
                           logic [REG_W-1:0] orr, logic [REG_W-1:0] ori,
                           logic [REG_W-1:0] sr, logic [REG_W-1:0] si,
                           logic [MAX_IT_W-1:0] cap);
    write_reg(REG_C_REAL, cr, 1'b0);
    write_reg(REG_C_IMAG, ci, 1'b0);
    write_reg(REG_ORIGIN_REAL, orr, 1'b0);
    write_reg(REG_ORIGIN_IMAG, ori, 1'b0);
    write_reg(REG_STEP_REAL, sr, 1'b0);
    write_reg(REG_STEP_IMAG, si, 1'b0);
    write_reg(REG_MAX_ITER, REG_W'(cap), 1'b1);
    settings++;
  endtask

  // Pixel transaction, with an occasional idle burst ahead of it
  task automatic send_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
    if (!calm && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.pixel_column <= col;
    in_ch.pixel_row    <= row;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold off new pixels until every predicted count has come back
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Result back-pressure in bursts of random length
  initial begin : result_ready_gen
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 6);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any transaction restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    clk                = 1'b0;
    rst_n              = 1'b0;
    calm               = 1'b0;
    settings           = 0;
    stall_cycles       = 0;
    in_ch.valid        = 1'b0;
    in_ch.pixel_column = '0;
    in_ch.pixel_row    = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: z stays at zero, so the count reaches the default cap
    send_pixel('0, '0);
    send_pixel('1, '1);
    settle();

    // classic view around the set, corners and alternating bit patterns
    load_view(q428(-0.8), q428(0.156), q428(-1.6), q428(-0.9),
              q428(3.2 / 4096.0), q428(1.8 / 4096.0), 16'd64);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd2000, 12'd2047);
    send_pixel(12'd1024, 12'd3000);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    settle();

    // zero cap, then a cap of one
    write_reg(REG_MAX_ITER, '0, 1'b1);
    send_pixel(12'd2000, 12'd2047);
    send_pixel(12'd4095, 12'd4095);
    settle();
    write_reg(REG_MAX_ITER, 32'd1, 1'b1);
    send_pixel(12'd2000, 12'd2047);
    send_pixel(12'd0, 12'd0);
    settle();

    // register extremes: start points and iterates saturate, largest cap
    load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    write_reg(REG_SPARE, 32'hFFFF_FFFF, 1'b1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd2, 12'd3);
    settle();

    // random views: mostly regions covering the set, two fully random ones
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      calm = (ph == RAND_PHASES - 1);
      if (ph == 2 || ph == 5) begin
        load_view($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  MAX_IT_W'($urandom_range(0, 40)));
      end else begin
        load_view(jitter(ONE), jitter(ONE),
                  q428(-2.0) + jitter(ONE / 4), q428(-2.0) + jitter(ONE / 4),
                  REG_W'($urandom_range(ONE / 1536, ONE / 1024 + ONE / 4096)),
                  REG_W'($urandom_range(ONE / 1536, ONE / 1024 + ONE / 4096)),
                  (ph == 6) ? MAX_IT_W'($urandom_range(128, 256))
                            : MAX_IT_W'($urandom_range(8, 64)));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
        if (ph == 3 && i == PHASE_ITEMS / 2) settle();
      end
      settle();
    end

    // catch any stray result after the last one
    repeat (20) @(negedge clk);
    $display("covered %0d pixel transactions under %0d register settings", checked, settings);
    $display("%0d counts hit the cap, %0d escaped before the first iteration", capped, instant);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/jet_pkg.sv
src/jet_if.sv
src/jet_front.sv
src/jet_queue.sv
src/jet_mul.sv
src/jet_back.sv
src/julia_escape_time_iterator_core.sv
dv/jet_count_checker.sv
dv/tb_julia_escape_time_iterator_core.sv
